@@ src/ptcf_pkg.sv @@
// Package for the positional tag class filter.
// Operation codes, pattern characters, parser modes and the row write bundle.
// No dependencies.
`default_nettype none

package ptcf_pkg;

  localparam int MAX_POSITIONS_DEF = 16;
  localparam int POS_W             = 7;
  localparam int ROW_W             = 256;
  localparam logic [POS_W-1:0] POS_LIMIT = 7'd127;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_TAG     = 2'd2;

  localparam logic [7:0] CH_ANY   = 8'h3F;  // '?'
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_NEG   = 8'h5E;  // '^'
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_OPENED  = 2'd1,
    MODE_FIRST   = 2'd2,
    MODE_MEMBERS = 2'd3
  } mode_t;

  // One row update: whole-row fill and/or a single bit write.
  typedef struct packed {
    logic             full;
    logic             fill;
    logic             bit_en;
    logic             bit_val;
    logic [7:0]       bit_sel;
    logic [POS_W-1:0] pos;
  } row_wr_t;

endpackage

`default_nettype wire

@@ src/ptcf_if.sv @@
// Channel interfaces of the positional tag class filter.
// Input items and result items, valid/ready handshake. No dependencies.
`default_nettype none

interface ptcf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output operation, output byte_value, output last,
                  input ready);
  modport sink (input valid, input operation, input byte_value, input last,
                output ready);
endinterface

interface ptcf_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_truncated;

  modport source (output valid, output matched, output pattern_truncated, input ready);
  modport sink (input valid, input matched, input pattern_truncated, output ready);
endinterface

`default_nettype wire

@@ src/positional_tag_class_filter_unit.sv @@
// Top level of the positional tag class filter: pattern parser, tag checker,
// input and result registers. Uses ptcf_pkg, ptcf_if and ptcf_row_store.
//
// Usage: in_ch carries items (operation, byte_value, last). Operation 0 clears
// the pattern, 1 feeds one pattern byte, 2 feeds one tag byte. A tag ends at a
// byte of value 0 or at a byte with last set; then one result (matched,
// pattern_truncated) is sent on out_ch. Other items give no result.
// Flow: an item is registered at its transfer and processed once the result
// slot is free; the tag byte that ends a tag passes the input register and then
// sets the output register, which raises out_ch.valid.
// One item per cycle is sustained while out_ch does not stall; a pattern item
// updates at most one row and a tag byte looks up one row.
// Stall: a result waits in the output register while out_ch.ready is low; the
// input register then holds one more item and in_ch.ready drops until the
// result transfers.
// Reset (rst_n low, synchronous): both registers empty, pattern cleared (all
// tags match), tag progress cleared. Row contents need no clearing.
`default_nettype none

module positional_tag_class_filter_unit
  import ptcf_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ptcf_in_if.sink   in_ch,
  ptcf_out_if.source out_ch
);

  localparam int IDXW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_POSITIONS);
  localparam logic [MAX_POSITIONS-1:0] POS_ONE = MAX_POSITIONS'(1);

  logic       in_valid_r;
  logic [1:0] op_r;
  logic [7:0] byte_r;
  logic       last_r;

  logic out_valid_r, out_valid_nxt;
  logic matched_r, trunc_out_r;

  logic [MAX_POSITIONS-1:0] active_r, active_nxt;
  logic [POS_W-1:0]         pp_r, pp_nxt, pp_inc;
  mode_t                    mode_r, mode_nxt;
  logic                     neg_r, neg_nxt;
  logic                     trunc_r, trunc_nxt;
  logic [POS_W-1:0]         tp_r, tp_nxt, fin_tp;
  logic                     rm_r, rm_nxt, fin_rm;
  logic                     ended_r, ended_nxt;

  logic                     in_xfer, out_free, process, fin, fin_ok, pp_ok;
  logic [MAX_POSITIONS-1:0] ge_mask, zero_col;
  logic                     rd_bit;
  row_wr_t                  wr;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign process  = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || process;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.matched           = matched_r;
  assign out_ch.pattern_truncated = trunc_out_r;

  ptcf_row_store #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_rows (
    .clk     (clk),
    .wr      (wr),
    .rd_pos  (tp_r),
    .rd_byte (byte_r),
    .rd_bit  (rd_bit),
    .zero_col(zero_col)
  );

  always_comb begin
    active_nxt = active_r;
    pp_nxt     = pp_r;
    mode_nxt   = mode_r;
    neg_nxt    = neg_r;
    trunc_nxt  = trunc_r;
    tp_nxt     = tp_r;
    rm_nxt     = rm_r;
    ended_nxt  = ended_r;
    fin        = 1'b0;
    fin_rm     = rm_r;
    fin_tp     = tp_r;
    wr         = '0;
    wr.pos     = pp_r;
    wr.bit_sel = byte_r;
    wr.bit_val = !neg_r;
    pp_inc     = (pp_r == POS_LIMIT) ? pp_r : pp_r + 7'd1;
    pp_ok      = pp_r < MAX_POS;

    case (op_r)
      OP_CLEAR: begin
        active_nxt = '0;
        pp_nxt     = '0;
        mode_nxt   = MODE_NORMAL;
        neg_nxt    = 1'b0;
        trunc_nxt  = 1'b0;
      end
      OP_PATTERN: begin
        if (pp_r == '0 && mode_r == MODE_NORMAL) begin
          active_nxt = '0;
          trunc_nxt  = 1'b0;
        end
        case (mode_r)
          MODE_NORMAL: begin
            if (byte_r == CH_ANY) begin
              pp_nxt = pp_inc;
            end else begin
              if (pp_ok) begin
                wr.full    = 1'b1;
                wr.fill    = 1'b0;
                active_nxt = active_nxt | (POS_ONE << pp_r);
              end else begin
                trunc_nxt = 1'b1;
              end
              if (byte_r == CH_OPEN) begin
                neg_nxt  = 1'b0;
                mode_nxt = MODE_OPENED;
              end else begin
                wr.bit_en  = pp_ok;
                wr.bit_val = 1'b1;
                pp_nxt     = pp_inc;
              end
            end
          end
          MODE_OPENED: begin
            if (byte_r == CH_NEG) begin
              neg_nxt  = 1'b1;
              wr.full  = pp_ok;
              wr.fill  = 1'b1;
              mode_nxt = MODE_FIRST;
            end else begin
              wr.bit_en = pp_ok;
              mode_nxt  = MODE_MEMBERS;
            end
          end
          MODE_FIRST: begin
            wr.bit_en = pp_ok;
            mode_nxt  = MODE_MEMBERS;
          end
          default: begin
            if (byte_r == CH_CLOSE) begin
              pp_nxt   = pp_inc;
              mode_nxt = MODE_NORMAL;
              neg_nxt  = 1'b0;
            end else begin
              wr.bit_en = pp_ok;
            end
          end
        endcase
        if (last_r) begin
          pp_nxt   = '0;
          mode_nxt = MODE_NORMAL;
          neg_nxt  = 1'b0;
        end
      end
      OP_TAG: begin
        if (ended_r) begin
          if (last_r) begin
            ended_nxt = 1'b0;
          end
        end else if (byte_r == 8'd0) begin
          if (!last_r) begin
            ended_nxt = 1'b1;
          end
          fin = 1'b1;
        end else begin
          fin_rm = rm_r && !((tp_r < MAX_POS) && active_r[tp_r[IDXW-1:0]] && !rd_bit);
          fin_tp = (tp_r == POS_LIMIT) ? tp_r : tp_r + 7'd1;
          rm_nxt = fin_rm;
          tp_nxt = fin_tp;
          fin    = last_r;
        end
      end
      default: ;
    endcase

    if (fin) begin
      rm_nxt = 1'b1;
      tp_nxt = '0;
    end
    if (!process) begin
      wr.full   = 1'b0;
      wr.bit_en = 1'b0;
    end
  end

  // active positions at or past the tag end must accept byte 0
  always_comb begin
    for (int p = 0; p < MAX_POSITIONS; p++) begin
      ge_mask[p] = POS_W'(p) >= fin_tp;
    end
  end

  assign fin_ok = fin_rm && !(|(active_r & ~zero_col & ge_mask));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (process && fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      pp_r        <= '0;
      mode_r      <= MODE_NORMAL;
      neg_r       <= 1'b0;
      trunc_r     <= 1'b0;
      tp_r        <= '0;
      rm_r        <= 1'b1;
      ended_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (process) begin
        in_valid_r <= 1'b0;
      end
      if (process) begin
        active_r <= active_nxt;
        pp_r     <= pp_nxt;
        mode_r   <= mode_nxt;
        neg_r    <= neg_nxt;
        trunc_r  <= trunc_nxt;
        tp_r     <= tp_nxt;
        rm_r     <= rm_nxt;
        ended_r  <= ended_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_ch.operation;
      byte_r <= in_ch.byte_value;
      last_r <= in_ch.last;
    end
    if (process && fin) begin
      matched_r   <= fin_ok;
      trunc_out_r <= trunc_r;
    end
  end

endmodule

`default_nettype wire

@@ src/ptcf_row_store.sv @@
// Acceptance row storage: one 256-bit row per pattern position.
// Single-bit and whole-row writes, one bit read by position, bit 0 of every row. Uses ptcf_pkg.
`default_nettype none

module ptcf_row_store
  import ptcf_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  wire logic                     clk,
  input  wire row_wr_t                  wr,
  input  wire logic [POS_W-1:0]         rd_pos,
  input  wire logic [7:0]               rd_byte,
  output logic                          rd_bit,
  output logic [MAX_POSITIONS-1:0]      zero_col
);

  localparam int IDXW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_POSITIONS);

  logic [ROW_W-1:0] row_r   [MAX_POSITIONS];
  logic [ROW_W-1:0] row_nxt [MAX_POSITIONS];
  logic [MAX_POSITIONS-1:0] row_we;

  always_comb begin
    for (int p = 0; p < MAX_POSITIONS; p++) begin
      row_we[p]  = (wr.pos == POS_W'(p)) && (wr.full || wr.bit_en);
      row_nxt[p] = wr.full ? {ROW_W{wr.fill}} : row_r[p];
      if (wr.bit_en) begin
        row_nxt[p][wr.bit_sel] = wr.bit_val;
      end
      zero_col[p] = row_r[p][0];
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_POSITIONS; p++) begin
      if (row_we[p]) begin
        row_r[p] <= row_nxt[p];
      end
    end
  end

  assign rd_bit = (rd_pos < MAX_POS) ? row_r[rd_pos[IDXW-1:0]][rd_byte] : 1'b0;

endmodule

`default_nettype wire

@@ src/ptcf_checker.sv @@
// Port-level checks for the positional tag class filter, bound to the top level.
// Depends on positional_tag_class_filter_unit ports only.
`default_nettype none

module ptcf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_matched,
  input wire logic out_pattern_truncated
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // a pending result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_matched)
      && $stable(out_pattern_truncated)))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // with the result slot empty the input side never stalls
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // no result appears unless an input transfer precedes it (checked now and at $past)
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !in_xfer && $past(!in_xfer)) |=> !out_valid)
    else $error("result without a preceding transfer");

endmodule

bind positional_tag_class_filter_unit ptcf_checker u_ptcf_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_matched          (out_ch.matched),
  .out_pattern_truncated(out_ch.pattern_truncated)
);

`default_nettype wire
